// ===== hdl/assert_macros.svh =====
// assertion macros shared by the cartridge bank controller rtl
// no dependencies; synthesis sees empty bodies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// clocked property, disabled while reset is low
`define CBC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked through reset as well
`define CBC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CBC_ASSERT(lbl, clk, rst_n, prop, msg)
`define CBC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hdl/cbc_pkg.sv =====
// types and constants for the cartridge bank controller
// no dependencies; used by the channel interfaces and the top level
package cbc_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DATA_W  = 8;
  localparam int unsigned PHYS_W  = 22;
  localparam int unsigned SIZE_W  = 23;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned CFG_W   = 23;

  typedef logic [2:0] region_t;
  typedef logic [1:0] fill_t;
  typedef logic [KIND_W-1:0] kind_t;

  // region codes
  localparam region_t REGION_FIXED_ROM  = 3'd0;
  localparam region_t REGION_BANKED_ROM = 3'd1;
  localparam region_t REGION_EXT_RAM    = 3'd2;
  localparam region_t REGION_RAM_BLOCKED = 3'd3;
  localparam region_t REGION_CONTROL    = 3'd4;
  localparam region_t REGION_NOT_CART   = 3'd5;
  localparam region_t REGION_DMA_DROP   = 3'd6;

  // read fill codes
  localparam fill_t FILL_MEMORY = 2'd0;
  localparam fill_t FILL_ZERO   = 2'd1;
  localparam fill_t FILL_ONES   = 2'd2;

  // cartridge kinds
  localparam kind_t KIND_NONE = 2'd0;
  localparam kind_t KIND_MBC1 = 2'd1;
  localparam kind_t KIND_MBC2 = 2'd2;

  // configuration register indexes
  localparam logic CFG_CART_KIND = 1'b0;
  localparam logic CFG_ROM_BYTES = 1'b1;

  localparam logic [SIZE_W-1:0] ROM_BYTES_RESET = 23'd32768;

  localparam logic [3:0]        RAM_EN_KEY    = 4'hA;
  localparam logic [DATA_W-1:0] BANK_LO_MASK  = 8'h1F;
  localparam logic [DATA_W-1:0] BANK_HI_MASK  = 8'h60;
  localparam logic [ADDR_W-1:0] MBC2_RAM_TOP  = 16'hA1FF;
  localparam logic [ADDR_W-1:0] DMA_LIMIT     = 16'hFE00;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] bus_address;
    logic [DATA_W-1:0] write_byte;
    logic              dma_busy;
  } in_item_t;

  typedef struct packed {
    region_t           region;
    logic [PHYS_W-1:0] phys_address;
    fill_t             read_fill;
    logic              crashed;
  } out_item_t;

endpackage

// ===== hdl/cbc_channels.sv =====
// valid/ready channel interfaces for the cartridge bank controller
// depends on cbc_pkg
interface cbc_in_if import cbc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              mode;
  logic [ADDR_W-1:0] bus_address;
  logic [DATA_W-1:0] write_byte;
  logic              dma_busy;

  modport source (output valid, mode, bus_address, write_byte, dma_busy, input ready);
  modport sink   (input valid, mode, bus_address, write_byte, dma_busy, output ready);
endinterface

interface cbc_out_if import cbc_pkg::*; ();
  logic              valid;
  logic              ready;
  region_t           region;
  logic [PHYS_W-1:0] phys_address;
  fill_t             read_fill;
  logic              crashed;

  modport source (output valid, region, phys_address, read_fill, crashed, input ready);
  modport sink   (input valid, region, phys_address, read_fill, crashed, output ready);
endinterface

// ===== hdl/cartridge_bank_controller.sv =====
// cartridge bank controller top level: mbc1/mbc2 address mapper
// depends on cbc_pkg, cbc_channels and assert_macros.svh
//
// Each accepted bus access (read or write) gives exactly one result from the
// result register: the region, the physical rom or external-ram byte
// address, the read fill code and the sticky crash flag after the access.
// An access enters an input register, is decoded by one short combinational
// pass that also updates the mapper registers, and lands in the result
// register. One access is taken per cycle while the result is not stalled.
// A stalled result holds the input register, which refills as soon as the
// result is taken.
// Configuration (cart kind, rom size) is written through cfg_we; the user
// must write it only while no access is in flight, as the block itself does
// not enforce it.
`include "assert_macros.svh"

module cartridge_bank_controller import cbc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  cbc_in_if.sink           in_ch,
  cbc_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  // configuration
  kind_t             cart_kind_r;
  logic [SIZE_W-1:0] rom_bytes_r;

  // mapper state
  logic              ram_en_r, ram_en_nxt;
  logic [DATA_W-1:0] bank_bits_r, bank_bits_nxt;
  logic              bank_mode_r, bank_mode_nxt;
  logic [DATA_W-1:0] rom_bank_r, rom_bank_nxt;
  logic [1:0]        ram_bank_r, ram_bank_nxt;
  logic              crash_r, crash_nxt;

  // pipeline
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r, out_item_nxt;
  logic      s1_adv;
  logic      in_fire;

  // decode
  logic              wr, dma, mbc1, mbc2;
  logic [ADDR_W-1:0] addr;
  logic [DATA_W-1:0] data;
  logic              relatch;
  logic [DATA_W-1:0] bank_new, bank_t, rom_bank_l;
  logic [1:0]        ram_bank_l;
  logic [SIZE_W-1:0] rom_span;

  assign s1_adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign wr   = s1_item_r.mode;
  assign dma  = s1_item_r.dma_busy;
  assign addr = s1_item_r.bus_address;
  assign data = s1_item_r.write_byte;
  assign mbc1 = (cart_kind_r == KIND_MBC1);
  assign mbc2 = (cart_kind_r == KIND_MBC2);

  // bank relatch from the new bank bits
  always_comb begin
    bank_t = bank_new;
    if ((bank_t & BANK_LO_MASK) == '0) begin
      bank_t = bank_t + 8'd1;
    end
    if (bank_mode_r) begin
      ram_bank_l = bank_t[6:5];
      rom_bank_l = bank_t & BANK_LO_MASK;
    end else begin
      ram_bank_l = 2'd0;
      rom_bank_l = bank_t;
    end
    rom_span = {({1'b0, rom_bank_l} + 9'd1), 14'd0};
  end

  always_comb begin
    ram_en_nxt    = ram_en_r;
    bank_mode_nxt = bank_mode_r;
    relatch       = 1'b0;
    bank_new      = bank_bits_r;
    out_item_nxt.region       = REGION_NOT_CART;
    out_item_nxt.phys_address = '0;
    out_item_nxt.read_fill    = FILL_MEMORY;

    if (wr && dma && addr < DMA_LIMIT) begin
      out_item_nxt.region = REGION_DMA_DROP;
    end else if (wr && !addr[15]) begin
      out_item_nxt.region = REGION_CONTROL;
      unique case (addr[14:13])
        2'd0: begin
          if (mbc1 || (mbc2 && !addr[8])) begin
            ram_en_nxt = (data[3:0] == RAM_EN_KEY);
          end
        end
        2'd1: begin
          if (mbc1) begin
            bank_new = (bank_bits_r & ~BANK_LO_MASK) | (data & BANK_LO_MASK);
            relatch  = 1'b1;
          end else if (mbc2) begin
            bank_new = data;
            relatch  = 1'b1;
          end
        end
        2'd2: begin
          if (mbc1) begin
            bank_new = (bank_bits_r & ~BANK_HI_MASK) | {1'b0, data[1:0], 5'd0};
            relatch  = 1'b1;
          end
        end
        default: begin
          if (mbc1) begin
            bank_mode_nxt = data[0];
          end
        end
      endcase
    end else if (!addr[15]) begin
      out_item_nxt.read_fill = crash_r ? FILL_ONES : FILL_MEMORY;
      if (!addr[14]) begin
        out_item_nxt.region       = REGION_FIXED_ROM;
        out_item_nxt.phys_address = {8'd0, addr[13:0]};
      end else begin
        out_item_nxt.region       = REGION_BANKED_ROM;
        out_item_nxt.phys_address = {rom_bank_r, addr[13:0]};
      end
    end else if (addr[15:13] == 3'b101) begin
      if (ram_en_r && (mbc1 || (mbc2 && addr <= MBC2_RAM_TOP))) begin
        out_item_nxt.region       = REGION_EXT_RAM;
        out_item_nxt.phys_address = {7'd0, ram_bank_r, addr[12:0]};
      end else begin
        out_item_nxt.region    = REGION_RAM_BLOCKED;
        out_item_nxt.read_fill = wr ? FILL_MEMORY : FILL_ZERO;
      end
    end

    if (relatch) begin
      bank_bits_nxt = bank_new;
      rom_bank_nxt  = rom_bank_l;
      ram_bank_nxt  = ram_bank_l;
      crash_nxt     = crash_r || (rom_span > rom_bytes_r);
    end else begin
      bank_bits_nxt = bank_bits_r;
      rom_bank_nxt  = rom_bank_r;
      ram_bank_nxt  = ram_bank_r;
      crash_nxt     = crash_r;
    end
    out_item_nxt.crashed = crash_nxt;
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cart_kind_r <= KIND_NONE;
      rom_bytes_r <= ROM_BYTES_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CART_KIND: cart_kind_r <= cfg_wdata[KIND_W-1:0];
        default:       rom_bytes_r <= cfg_wdata[SIZE_W-1:0];
      endcase
    end
  end

  // mapper state, updated as the access leaves the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ram_en_r    <= 1'b0;
      bank_bits_r <= '0;
      bank_mode_r <= 1'b0;
      rom_bank_r  <= 8'd1;
      ram_bank_r  <= 2'd0;
      crash_r     <= 1'b0;
    end else if (s1_adv) begin
      ram_en_r    <= ram_en_nxt;
      bank_bits_r <= bank_bits_nxt;
      bank_mode_r <= bank_mode_nxt;
      rom_bank_r  <= rom_bank_nxt;
      ram_bank_r  <= ram_bank_nxt;
      crash_r     <= crash_nxt;
    end
  end

  // input register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.mode        <= in_ch.mode;
      s1_item_r.bus_address <= in_ch.bus_address;
      s1_item_r.write_byte  <= in_ch.write_byte;
      s1_item_r.dma_busy    <= in_ch.dma_busy;
    end
    if (s1_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.region       = out_item_r.region;
  assign out_ch.phys_address = out_item_r.phys_address;
  assign out_ch.read_fill    = out_item_r.read_fill;
  assign out_ch.crashed      = out_item_r.crashed;

  `CBC_ASSERT(a_crash_sticky, clk, rst_n, crash_r |=> crash_r, "crash flag cleared")
  `CBC_ASSERT(a_rom_bank_nonzero, clk, rst_n, rom_bank_r[4:0] != 5'd0, "rom bank low bits zero")
  `CBC_ASSERT(a_result_from_s1, clk, rst_n, $rose(out_valid_r) |-> $past(s1_valid_r), "result without access")
  `CBC_ASSERT(a_crashed_tracks, clk, rst_n, s1_adv |=> (out_ch.crashed == crash_r), "crashed out of step")
  `CBC_ASSERT_ALWAYS(a_empty_ready, clk, !s1_valid_r |-> in_ch.ready, "empty stage not ready")

endmodule
